>>> sv/vfo_tuning_controller_unit_defines.svh
// Assertion macros shared by the VFO tuning controller RTL.
`ifndef VFO_TUNING_CONTROLLER_UNIT_DEFINES_SVH
`define VFO_TUNING_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VFOTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vfotc same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define VFOTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vfotc next-cycle check failed");

`endif

>>> sv/vfotc_pkg.sv
// Types, constants and lookup tables for the VFO tuning controller.
package vfotc_pkg;

  typedef enum logic [1:0] {
    KIND_TURN   = 2'd0,
    KIND_STEP   = 2'd1,
    KIND_PRESET = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  localparam logic signed [1:0] DIR_UP   = 2'sb01;
  localparam logic signed [1:0] DIR_DOWN = 2'sb11;

  localparam logic [1:0] REG_TUNE_ENABLE = 2'd0;
  localparam logic [1:0] REG_IF_OFFSET   = 2'd1;
  localparam logic [1:0] REG_DIRECT_MODE = 2'd2;

  localparam logic [27:0] FREQ_MAX      = 28'd225000000;
  localparam logic [27:0] FREQ_MIN      = 28'd10000;
  localparam logic [27:0] FREQ_RESET    = 28'd7200000;
  localparam logic [19:0] STEP_MHZ      = 20'd1000000;
  localparam logic [19:0] PRESET_STEP   = 20'd5000;
  localparam logic [2:0]  PRESET_POS    = 3'd5;
  localparam logic [2:0]  STEP_POS_LAST = 3'd6;
  localparam logic [4:0]  TABLE_BANDS   = 5'd21;
  localparam logic [34:0] CHZ_PER_HZ    = 35'd100;
  localparam logic [34:0] CHZ_PER_KHZ   = 35'd100000;

  typedef struct packed {
    logic        tune_enable;
    logic [16:0] if_offset_khz;
    logic        direct_mode;
  } cfg_t;

  typedef struct packed {
    logic [27:0] frequency_hz;
    logic [19:0] step_hz;
    logic [2:0]  step_position;
    logic [4:0]  band_number;
    logic [5:0]  dial_count;
    logic        pll_restart;
    logic        retune;
    logic [34:0] freq_chz;
    logic [34:0] if_chz;
  } result_t;

  function automatic logic [27:0] band_freq(input logic [4:0] band);
    logic [27:0] f;
    case (band)
      5'd1:    f = 28'd100000;
      5'd2:    f = 28'd800000;
      5'd3:    f = 28'd1800000;
      5'd4:    f = 28'd3650000;
      5'd5:    f = 28'd4985000;
      5'd6:    f = 28'd6180000;
      5'd7:    f = 28'd7200000;
      5'd8:    f = 28'd10000000;
      5'd9:    f = 28'd11780000;
      5'd10:   f = 28'd13630000;
      5'd11:   f = 28'd14100000;
      5'd12:   f = 28'd15000000;
      5'd13:   f = 28'd17655000;
      5'd14:   f = 28'd21525000;
      5'd15:   f = 28'd27015000;
      5'd16:   f = 28'd28400000;
      5'd17:   f = 28'd50000000;
      5'd18:   f = 28'd100000000;
      5'd19:   f = 28'd130000000;
      5'd20:   f = 28'd144000000;
      5'd21:   f = 28'd220000000;
      default: f = 28'd0;
    endcase
    return f;
  endfunction

  function automatic logic [19:0] step_for_pos(input logic [2:0] pos);
    logic [19:0] s;
    case (pos)
      3'd1:    s = 20'd1;
      3'd2:    s = 20'd10;
      3'd3:    s = 20'd1000;
      3'd4:    s = 20'd5000;
      3'd5:    s = 20'd10000;
      3'd6:    s = 20'd1000000;
      default: s = 20'd0;
    endcase
    return s;
  endfunction

endpackage

>>> sv/vfotc_ctrl.sv
// Tuning state registers and the next-state logic for one event.
module vfotc_ctrl import vfotc_pkg::*; #(
  parameter int BAND_COUNT     = 21,
  parameter int DIAL_POSITIONS = 42
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [1:0]        kind,
  input  logic signed [1:0] dir,
  input  cfg_t              cfg,
  output result_t           res
);

  localparam logic [5:0] DIAL_MAX = 6'(DIAL_POSITIONS);
  localparam logic [5:0] BAND_MAX = 6'(BAND_COUNT);
  localparam logic signed [29:0] F_MAX_S = 30'sd225000000;
  localparam logic signed [29:0] F_MIN_S = 30'sd10000;
  localparam logic signed [29:0] F_MHZ_S = 30'sd1000000;

  logic [27:0] freq_r, freq_nxt;
  logic [19:0] step_r, step_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [4:0]  band_r, band_nxt;
  logic [5:0]  dial_r, dial_nxt;
  logic [16:0] aif_r, aif_nxt;
  logic        pll_nxt, retune_nxt;

  logic signed [29:0] f_w;
  logic [6:0]         d_w;
  logic [5:0]         band_sum;
  kind_t              kind_e;

  assign kind_e = kind_t'(kind);

  always_comb begin
    freq_nxt   = freq_r;
    step_nxt   = step_r;
    pos_nxt    = pos_r;
    band_nxt   = band_r;
    dial_nxt   = dial_r;
    aif_nxt    = aif_r;
    pll_nxt    = 1'b0;
    retune_nxt = 1'b0;
    f_w        = {2'b00, freq_r};
    d_w        = {1'b0, dial_r};
    band_sum   = {1'b0, band_r} + 6'd1;

    case (kind_e)
      KIND_TURN: begin
        if (cfg.tune_enable) begin
          if (dir == DIR_UP) begin
            f_w = f_w + {10'd0, step_r};
          end
          if (f_w >= F_MAX_S) begin
            f_w = F_MAX_S;
          end
          if (dir == DIR_DOWN) begin
            f_w = f_w - {10'd0, step_r};
          end
          if (step_r == STEP_MHZ && f_w <= F_MHZ_S) begin
            f_w = F_MHZ_S;
          end else if (f_w < F_MIN_S) begin
            f_w = F_MIN_S;
          end
          freq_nxt = f_w[27:0];

          if (dir == DIR_UP) begin
            d_w = d_w + 7'd1;
          end
          if (d_w > {1'b0, DIAL_MAX}) begin
            d_w = 7'd1;
          end
          if (dir == DIR_DOWN) begin
            d_w = (d_w <= 7'd1) ? {1'b0, DIAL_MAX} : d_w - 7'd1;
          end else if (d_w == 7'd0) begin
            d_w = {1'b0, DIAL_MAX};
          end
          dial_nxt = d_w[5:0];
        end
      end
      KIND_STEP: begin
        if (pos_r >= 3'd1 && pos_r <= STEP_POS_LAST) begin
          step_nxt = step_for_pos(pos_r);
          pos_nxt  = (pos_r == STEP_POS_LAST) ? 3'd1 : pos_r + 3'd1;
        end
      end
      KIND_PRESET: begin
        band_nxt = (band_sum > BAND_MAX) ? 5'd1 : band_sum[4:0];
        if (band_nxt >= 5'd1 && band_nxt <= TABLE_BANDS) begin
          freq_nxt = band_freq(band_nxt);
        end
        step_nxt = PRESET_STEP;
        pos_nxt  = PRESET_POS;
        if (band_nxt == 5'd1) begin
          aif_nxt = 17'd0;
        end else if (!cfg.direct_mode) begin
          aif_nxt = cfg.if_offset_khz;
        end
        pll_nxt    = 1'b1;
        retune_nxt = (band_nxt == 5'd1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= FREQ_RESET;
      step_r <= PRESET_STEP;
      pos_r  <= PRESET_POS;
      band_r <= 5'd0;
      dial_r <= 6'd1;
      aif_r  <= 17'd0;
    end else if (accept) begin
      freq_r <= freq_nxt;
      step_r <= step_nxt;
      pos_r  <= pos_nxt;
      band_r <= band_nxt;
      dial_r <= dial_nxt;
      aif_r  <= aif_nxt;
    end
  end

  always_comb begin
    res.frequency_hz  = freq_nxt;
    res.step_hz       = step_nxt;
    res.step_position = pos_nxt;
    res.band_number   = band_nxt;
    res.dial_count    = dial_nxt;
    res.pll_restart   = pll_nxt;
    res.retune        = retune_nxt;
    res.freq_chz      = {7'd0, freq_nxt} * CHZ_PER_HZ;
    res.if_chz        = {18'd0, aif_nxt} * CHZ_PER_KHZ;
  end

endmodule

>>> sv/vfotc_out.sv
// Result pipeline: product register, synthesizer word add and output register.
module vfotc_out import vfotc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  result_t     res,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [27:0] out_frequency_hz,
  output logic [34:0] out_synth_centihertz,
  output logic [19:0] out_step_hz,
  output logic [2:0]  out_step_position,
  output logic [4:0]  out_band_number,
  output logic [5:0]  out_dial_count,
  output logic        out_pll_restart,
  output logic        out_retune
);

  logic    s1_v_r;
  result_t s1_r;
  logic    s1_adv;
  logic    out_v_r;

  assign s1_adv    = !out_v_r || out_ready;
  assign in_ready  = !s1_v_r || s1_adv;
  assign out_valid = out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (s1_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= res;
    end
    if (s1_adv && s1_v_r) begin
      out_frequency_hz     <= s1_r.frequency_hz;
      out_synth_centihertz <= s1_r.freq_chz + s1_r.if_chz;
      out_step_hz          <= s1_r.step_hz;
      out_step_position    <= s1_r.step_position;
      out_band_number      <= s1_r.band_number;
      out_dial_count       <= s1_r.dial_count;
      out_pll_restart      <= s1_r.pll_restart;
      out_retune           <= s1_r.retune;
    end
  end

endmodule

>>> sv/vfo_tuning_controller_unit.sv
// Top level of the VFO tuning controller: configuration registers and block wiring.
//
// One request is accepted per clock cycle, back to back, while the output side does not
// stall. Each request gives one result: on acceptance the tuning state is updated and
// the frequency and IF products are registered, then they are added into the
// synthesizer word in the output register. Configuration writes take effect on the
// next request.
`include "vfo_tuning_controller_unit_defines.svh"

module vfo_tuning_controller_unit import vfotc_pkg::*; #(
  parameter int BAND_COUNT     = 21,
  parameter int DIAL_POSITIONS = 42
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic signed [1:0] in_dir,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [27:0]       out_frequency_hz,
  output logic [34:0]       out_synth_centihertz,
  output logic [19:0]       out_step_hz,
  output logic [2:0]        out_step_position,
  output logic [4:0]        out_band_number,
  output logic [5:0]        out_dial_count,
  output logic              out_pll_restart,
  output logic              out_retune,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [16:0]       cfg_wdata
);

  localparam logic [5:0] DIAL_MAX = 6'(DIAL_POSITIONS);

  cfg_t    cfg_r;
  result_t res;
  logic    in_fire;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tune_enable   <= 1'b1;
      cfg_r.if_offset_khz <= 17'd0;
      cfg_r.direct_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TUNE_ENABLE: cfg_r.tune_enable   <= cfg_wdata[0];
        REG_IF_OFFSET:   cfg_r.if_offset_khz <= cfg_wdata;
        REG_DIRECT_MODE: cfg_r.direct_mode   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  vfotc_ctrl #(
    .BAND_COUNT     (BAND_COUNT),
    .DIAL_POSITIONS (DIAL_POSITIONS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_fire),
    .kind   (in_kind),
    .dir    (in_dir),
    .cfg    (cfg_r),
    .res    (res)
  );

  vfotc_out u_out (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .res                  (res),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_frequency_hz     (out_frequency_hz),
    .out_synth_centihertz (out_synth_centihertz),
    .out_step_hz          (out_step_hz),
    .out_step_position    (out_step_position),
    .out_band_number      (out_band_number),
    .out_dial_count       (out_dial_count),
    .out_pll_restart      (out_pll_restart),
    .out_retune           (out_retune)
  );

  `VFOTC_ASSERT_IMP(a_step_pos_range, out_valid, out_step_position >= 3'd1 && out_step_position <= STEP_POS_LAST)
  `VFOTC_ASSERT_IMP(a_dial_range, out_valid, out_dial_count >= 6'd1 && out_dial_count <= DIAL_MAX)
  `VFOTC_ASSERT_IMP(a_preset_step, out_valid && out_pll_restart, out_step_hz == PRESET_STEP && out_step_position == PRESET_POS)
  `VFOTC_ASSERT_IMP(a_retune_band1, out_valid && out_retune, out_pll_restart && out_band_number == 5'd1)
  `VFOTC_ASSERT_NXT(a_freq_cap, out_valid && out_ready, !out_valid || out_frequency_hz <= FREQ_MAX)

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the VFO tuning controller unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vfotc_pkg::*;

  localparam int BAND_COUNT     = 21;
  localparam int DIAL_POSITIONS = 42;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_LIMIT    = 2000;
  localparam int HOLD_OFF_CYCLES = 120;

  localparam logic signed [1:0] DIR_NONE = 2'sb00;
  localparam logic signed [1:0] DIR_SKIP = 2'sb10;
  localparam logic [1:0]        REG_SPARE = 2'd3;

  localparam int unsigned BAND_HZ [BAND_COUNT] = '{
    100000, 800000, 1800000, 3650000, 4985000, 6180000, 7200000,
    10000000, 11780000, 13630000, 14100000, 15000000, 17655000,
    21525000, 27015000, 28400000, 50000000, 100000000, 130000000,
    144000000, 220000000
  };
  localparam int unsigned STEP_CYCLE_HZ [6] = '{1, 10, 1000, 5000, 10000, 1000000};

  typedef struct packed {
    logic [27:0] frequency_hz;
    logic [34:0] synth_centihertz;
    logic [19:0] step_hz;
    logic [2:0]  step_position;
    logic [4:0]  band_number;
    logic [5:0]  dial_count;
    logic        pll_restart;
    logic        retune;
  } reading_t;

  class tuning_tracker;
    logic [27:0] freq;
    logic [19:0] step;
    logic [2:0]  step_pos;
    logic [4:0]  band;
    logic [5:0]  dial;
    logic [16:0] active_if;
    bit          tune_en;
    logic [16:0] if_offset;
    bit          direct;
    reading_t    expected_readings[$];
    int          errors;
    int          checked;

    function new();
      freq = FREQ_RESET;
      step = PRESET_STEP;
      step_pos = PRESET_POS;
      band = '0;
      dial = 6'd1;
      active_if = '0;
      tune_en = 1'b1;
      if_offset = '0;
      direct = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [16:0] data);
      case (idx)
        REG_TUNE_ENABLE: tune_en = data[0];
        REG_IF_OFFSET:   if_offset = data;
        REG_DIRECT_MODE: direct = data[0];
        default: ;
      endcase
    endfunction

    function void note_request(kind_t k, logic signed [1:0] d);
      longint f;
      int dl;
      logic [63:0] word;
      reading_t r;
      r.pll_restart = 1'b0;
      r.retune = 1'b0;
      case (k)
        KIND_TURN: begin
          if (tune_en) begin
            f = longint'(freq);
            if (d == DIR_UP) f = f + longint'(step);
            if (f >= longint'(FREQ_MAX)) f = longint'(FREQ_MAX);
            if (d == DIR_DOWN) f = f - longint'(step);
            if (step == STEP_MHZ && f <= longint'(STEP_MHZ)) f = longint'(STEP_MHZ);
            else if (f < longint'(FREQ_MIN)) f = longint'(FREQ_MIN);
            freq = 28'(f);
            dl = int'(dial);
            if (d == DIR_UP) dl = dl + 1;
            if (dl > DIAL_POSITIONS) dl = 1;
            if (d == DIR_DOWN) dl = dl - 1;
            if (dl < 1) dl = DIAL_POSITIONS;
            dial = 6'(dl);
          end
        end
        KIND_STEP: begin
          if (step_pos >= 3'd1 && step_pos <= STEP_POS_LAST) begin
            step = 20'(STEP_CYCLE_HZ[step_pos - 3'd1]);
            step_pos = (step_pos == STEP_POS_LAST) ? 3'd1 : step_pos + 3'd1;
          end
        end
        KIND_PRESET: begin
          band = band + 5'd1;
          if (band > BAND_COUNT) band = 5'd1;
          if (band >= 5'd1 && band <= TABLE_BANDS) freq = 28'(BAND_HZ[band - 5'd1]);
          step = PRESET_STEP;
          step_pos = PRESET_POS;
          if (band == 5'd1) active_if = '0;
          else if (!direct) active_if = if_offset;
          r.pll_restart = 1'b1;
          r.retune = (band == 5'd1);
        end
        default: ;
      endcase
      word = (64'(freq) + 64'(active_if) * 64'd1000) * 64'd100;
      r.frequency_hz = freq;
      r.synth_centihertz = word[34:0];
      r.step_hz = step;
      r.step_position = step_pos;
      r.band_number = band;
      r.dial_count = dial;
      expected_readings.push_back(r);
    endfunction

    function void compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(reading_t got);
      reading_t exp_r;
      if (expected_readings.size() == 0) begin
        errors++;
        $display("%0t: result with no request waiting, actual frequency %0d",
                 $time, got.frequency_hz);
        return;
      end
      exp_r = expected_readings.pop_front();
      checked++;
      compare_field("frequency_hz", exp_r.frequency_hz, got.frequency_hz);
      compare_field("synth_centihertz", exp_r.synth_centihertz, got.synth_centihertz);
      compare_field("step_hz", exp_r.step_hz, got.step_hz);
      compare_field("step_position", exp_r.step_position, got.step_position);
      compare_field("band_number", exp_r.band_number, got.band_number);
      compare_field("dial_count", exp_r.dial_count, got.dial_count);
      compare_field("pll_restart", exp_r.pll_restart, got.pll_restart);
      compare_field("retune", exp_r.retune, got.retune);
    endfunction

    function int outstanding();
      return expected_readings.size();
    endfunction

    function void flag_leftovers();
      if (expected_readings.size() != 0) begin
        errors += expected_readings.size();
        $display("%0t: %0d expected results never arrived", $time, expected_readings.size());
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_kind = '0;
  logic signed [1:0] in_dir = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [27:0]       out_frequency_hz;
  logic [34:0]       out_synth_centihertz;
  logic [19:0]       out_step_hz;
  logic [2:0]        out_step_position;
  logic [4:0]        out_band_number;
  logic [5:0]        out_dial_count;
  logic              out_pll_restart;
  logic              out_retune;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [16:0]       cfg_wdata = '0;

  tuning_tracker tracker = new();
  bit steady_phase = 1'b0;
  int requests_sent = 0;
  int cycle_count = 0;

  vfo_tuning_controller_unit #(
    .BAND_COUNT    (BAND_COUNT),
    .DIAL_POSITIONS(DIAL_POSITIONS)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_dir              (in_dir),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frequency_hz    (out_frequency_hz),
    .out_synth_centihertz(out_synth_centihertz),
    .out_step_hz         (out_step_hz),
    .out_step_position   (out_step_position),
    .out_band_number     (out_band_number),
    .out_dial_count      (out_dial_count),
    .out_pll_restart     (out_pll_restart),
    .out_retune          (out_retune),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    reading_t got;
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.frequency_hz = out_frequency_hz;
        got.synth_centihertz = out_synth_centihertz;
        got.step_hz = out_step_hz;
        got.step_position = out_step_position;
        got.band_number = out_band_number;
        got.dial_count = out_dial_count;
        got.pll_restart = out_pll_restart;
        got.retune = out_retune;
        tracker.check_result(got);
      end
      if (!hold_done && tracker.checked >= 300) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (steady_phase) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 20);
      end
    end
  end

  task automatic send_request(kind_t k, logic [1:0] d);
    if (!steady_phase) begin
      while ($urandom_range(99) < 20) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_dir <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_request(k, d);
    requests_sent++;
  endtask

  task automatic write_register(logic [1:0] idx, logic [16:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.set_register(idx, data);
  endtask

  task automatic run_tuning_sequence();
    int presses;
    int len;
    logic [1:0] d;
    logic [1:0] turn_dir;
    if ($urandom_range(1)) send_request(KIND_PRESET, 2'($urandom));
    presses = $urandom_range(0, 3);
    repeat (presses) send_request(KIND_STEP, 2'($urandom));
    len = $urandom_range(1, 24);
    if (tracker.freq > 28'd100000000) d = ($urandom_range(3) != 0) ? DIR_UP : DIR_DOWN;
    else if (tracker.freq < 28'd1000000) d = ($urandom_range(3) != 0) ? DIR_DOWN : DIR_UP;
    else d = $urandom_range(1) ? DIR_UP : DIR_DOWN;
    repeat (len) begin
      turn_dir = d;
      if ($urandom_range(9) == 0) turn_dir = $urandom_range(1) ? DIR_NONE : DIR_SKIP;
      send_request(KIND_TURN, turn_dir);
    end
  endtask

  task automatic run_phase(bit te, logic [16:0] offset, bit dm, int target, bit steady);
    in_valid <= 1'b0;
    while (tracker.outstanding() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_register(REG_TUNE_ENABLE, {16'($urandom), te});
    write_register(REG_IF_OFFSET, offset);
    write_register(REG_DIRECT_MODE, {16'($urandom), dm});
    if (target > 1000) write_register(REG_SPARE, 17'($urandom));
    cfg_we <= 1'b0;
    steady_phase = steady;
    while (requests_sent < target) begin
      if ($urandom_range(9) < 8) send_request(kind_t'($urandom_range(0, 3)), 2'($urandom));
      else run_tuning_sequence();
    end
    steady_phase = 1'b0;
  endtask

  initial begin
    int drain_cycles;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(KIND_TURN, DIR_UP);
    send_request(KIND_TURN, DIR_DOWN);
    send_request(KIND_TURN, DIR_DOWN);
    send_request(KIND_TURN, DIR_UP);
    send_request(KIND_TURN, DIR_NONE);
    send_request(KIND_TURN, DIR_SKIP);
    send_request(KIND_NONE, 2'($urandom));
    send_request(KIND_PRESET, DIR_NONE);
    send_request(KIND_STEP, DIR_NONE);
    send_request(KIND_STEP, DIR_NONE);
    send_request(KIND_TURN, DIR_DOWN);
    send_request(KIND_TURN, DIR_UP);
    send_request(KIND_TURN, DIR_DOWN);
    send_request(KIND_TURN, DIR_DOWN);
    send_request(KIND_STEP, DIR_NONE);
    send_request(KIND_TURN, DIR_DOWN);
    repeat (4) send_request(KIND_STEP, DIR_NONE);
    send_request(KIND_PRESET, DIR_UP);

    run_phase(1'b1, 17'd100000, 1'b0, 240, 1'b0);
    run_phase(1'b1, 17'h1FFFF, 1'b0, 470, 1'b0);
    run_phase(1'b0, 17'($urandom_range(0, 100000)), 1'b1, 700, 1'b0);
    run_phase(1'b1, 17'($urandom_range(0, 100000)), 1'b1, 930, 1'b1);
    run_phase(1'b1, 17'd0, 1'b0, 1150, 1'b0);

    in_valid <= 1'b0;
    drain_cycles = 0;
    while (tracker.outstanding() > 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    tracker.flag_leftovers();
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
